// ===== rtl/wtns_pkg.sv =====
// Package for the weighted top-N selector: payload structs, FSM state type,
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package wtns_pkg;
   localparam int COUNT_W = 40;
   localparam int INDEX_W = 11;
   localparam int PICK_W  = 7;
   localparam int CSR_PICK_COUNT = 0;

   typedef struct packed {
      logic [COUNT_W-1:0] play_count;
      logic               last_song;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] song_index;
      logic               last_pick;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_LOAD  = 2'd0,
      ST_MULT  = 2'd1,
      ST_EMIT  = 2'd2
   } state_type;

   typedef struct packed {
      logic mult;    // capture product of item
      logic insert;  // insert captured score into chain
      logic shift;   // pop head of chain to output
      logic clear;   // clear chain and counter
   } cmd_type;

   typedef struct packed {
      logic head_valid;  // chain position 0 holds an entry
      logic next_valid;  // chain position 1 holds an entry
   } sts_type;
endpackage
`default_nettype wire

// ===== rtl/wtns_datapath.sv =====
// Datapath: entry counter, score multiply register and sorted insertion chain.
// Depends on wtns_pkg.
`default_nettype none
module wtns_datapath #(
   parameter int MAX_PICKS = 64,
   parameter int MAX_SONGS = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire wtns_pkg::cmd_type             cmd,
   input  wire logic [wtns_pkg::COUNT_W-1:0]  play_count,
   output wtns_pkg::sts_type                  sts,
   output logic [wtns_pkg::INDEX_W-1:0]       head_index
);
   localparam int CNT_W   = $clog2(MAX_SONGS + 1);
   localparam int SCORE_W = wtns_pkg::COUNT_W + CNT_W;

   logic [CNT_W-1:0]   counter_ff, counter_in;
   logic [SCORE_W-1:0] score_ff;
   logic [CNT_W-1:0]   sidx_ff;
   logic               sval_ff;
   logic [SCORE_W-1:0] score_q [MAX_PICKS];
   logic [CNT_W-1:0]   index_q [MAX_PICKS];
   logic [MAX_PICKS-1:0] valid_ff;
   logic [MAX_PICKS-1:0] tail_valid;
   logic [MAX_PICKS-1:0] beats;   // slot k holds an entry that stays ahead

   assign counter_in = counter_ff + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         counter_ff <= '0;
      end else if (cmd.mult && counter_ff < CNT_W'(MAX_SONGS)) begin
         counter_ff <= counter_in;
      end
   end

   // One multiplier, registered before the compare chain.
   always_ff @(posedge clock) begin
      if (reset) begin
         sval_ff <= 1'b0;
      end else begin
         sval_ff <= cmd.mult && counter_ff < CNT_W'(MAX_SONGS);
      end
      score_ff <= SCORE_W'(play_count) * SCORE_W'(counter_in);
      sidx_ff  <= counter_in;
   end

   always_comb begin
      for (int k = 0; k < MAX_PICKS; k++) begin
         beats[k] = valid_ff[k] && score_q[k] >= score_ff;
      end
   end

   // On insert each cell keeps, takes the new entry, or takes the entry of slot k-1.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         valid_ff <= '0;
      end else if (cmd.shift) begin
         valid_ff <= {1'b0, valid_ff[MAX_PICKS-1:1]};
      end else if (cmd.insert && sval_ff) begin
         for (int k = 0; k < MAX_PICKS; k++) begin
            if (!beats[k]) begin
               valid_ff[k] <= (k == 0) ? 1'b1 : (beats[k-1] ? 1'b1 : valid_ff[k-1]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         for (int k = 0; k < MAX_PICKS - 1; k++) begin
            score_q[k] <= score_q[k+1];
            index_q[k] <= index_q[k+1];
         end
      end else if (cmd.insert && sval_ff) begin
         for (int k = 0; k < MAX_PICKS; k++) begin
            if (!beats[k]) begin
               if (k == 0 || beats[k-1]) begin
                  score_q[k] <= score_ff;
                  index_q[k] <= sidx_ff;
               end else begin
                  score_q[k] <= score_q[k-1];
                  index_q[k] <= index_q[k-1];
               end
            end
         end
      end
   end

   // Valid bits form a run from slot 0, so slot 1 tells if the head is the final entry.
   assign tail_valid     = valid_ff >> 1;
   assign sts.head_valid = valid_ff[0];
   assign sts.next_valid = tail_valid[0];
   assign head_index     = wtns_pkg::INDEX_W'(index_q[0]);
endmodule
`default_nettype wire

// ===== rtl/wtns_ctrl.sv =====
// Controller FSM: sequences load, insert and emit burst.
// Depends on wtns_pkg.
`default_nettype none
module wtns_ctrl #(
   parameter int MAX_PICKS = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         last_song,
   input  wire logic [wtns_pkg::PICK_W-1:0]  pick_count,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              last_pick,
   input  wire wtns_pkg::sts_type            sts,
   output wtns_pkg::cmd_type                 cmd
);
   wtns_pkg::state_type state_ff, state_in;
   logic [wtns_pkg::PICK_W-1:0] left_ff, left_in;
   logic last_ff;
   logic [wtns_pkg::PICK_W-1:0] limit;
   logic take, pop;

   assign limit = (pick_count > wtns_pkg::PICK_W'(MAX_PICKS))
                  ? wtns_pkg::PICK_W'(MAX_PICKS) : pick_count;
   assign take = req_valid && req_ready;
   assign pop  = rsp_valid && rsp_ready;

   always_comb begin
      state_in = state_ff;
      left_in  = left_ff;
      case (state_ff)
         wtns_pkg::ST_LOAD: begin
            if (take) state_in = wtns_pkg::ST_MULT;
         end
         wtns_pkg::ST_MULT: begin
            if (last_ff) begin
               state_in = wtns_pkg::ST_EMIT;
               left_in  = limit;
            end else begin
               state_in = wtns_pkg::ST_LOAD;
            end
         end
         wtns_pkg::ST_EMIT: begin
            if (left_ff == '0 || !sts.head_valid) begin
               state_in = wtns_pkg::ST_LOAD;
            end else if (pop) begin
               left_in = left_ff - wtns_pkg::PICK_W'(1);
            end
         end
         default: state_in = wtns_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      cmd        = '0;
      case (state_ff)
         wtns_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            cmd.mult  = take;
         end
         wtns_pkg::ST_MULT: cmd.insert = 1'b1;
         wtns_pkg::ST_EMIT: begin
            rsp_valid = left_ff != '0 && sts.head_valid;
            cmd.shift = pop;
            cmd.clear = left_ff == '0 || !sts.head_valid;
         end
         default: ;
      endcase
   end

   // Last pick: final of the limit, or chain runs dry after this one.
   assign last_pick = left_ff == wtns_pkg::PICK_W'(1) || !sts.next_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wtns_pkg::ST_LOAD;
         left_ff  <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         left_ff  <= left_in;
         if (take) last_ff <= last_song;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == wtns_pkg::ST_EMIT) else $error("rsp outside emit");
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("load during emit");
   assert property (@(posedge clock) disable iff (reset)
      pop |=> left_ff == $past(left_ff) - wtns_pkg::PICK_W'(1) || state_ff == wtns_pkg::ST_LOAD)
      else $error("emit count slip");
endmodule
`default_nettype wire

// ===== rtl/weighted_top_n_selector_top.sv =====
// Top level of the weighted top-N selector: CSR, controller and datapath.
// Depends on wtns_pkg, wtns_ctrl, wtns_datapath.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_valid/req_ready  | wtns_pkg::req_type (play_count, last_song)
//  rsp     | out | rsp_valid/rsp_ready  | wtns_pkg::rsp_type (song_index, last_pick)
//  csr     | in  | APB psel/penable     | pick_count at address 0
//
// Each item is multiplied (count by index) in LOAD and inserted into the 64-cell
// compare-and-shift chain in MULT; no new item is taken before the insert. After a
// last item, up to pick_count results (no more than were loaded) follow one per
// cycle from the chain head while rsp_ready is high; then the chain is cleared.
// Reset is synchronous and returns pick_count to 1 and empties the chain.
// A stalled rsp holds the chain head; req is not taken during the burst.
`default_nettype none
module weighted_top_n_selector_top #(
   parameter int MAX_PICKS = 64,
   parameter int MAX_SONGS = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire wtns_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output wtns_pkg::rsp_type       rsp_data,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [0:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   logic [wtns_pkg::PICK_W-1:0] pick_ff;
   wtns_pkg::cmd_type cmd;
   wtns_pkg::sts_type sts;
   logic [wtns_pkg::INDEX_W-1:0] head_index;
   logic last_pick;

   assign pready = 1'b1;
   // Single register at address 0; paddr bit 0 is decoded, so address 1 does not write it.
   always_ff @(posedge clock) begin
      if (reset) begin
         pick_ff <= wtns_pkg::PICK_W'(1);
      end else if (psel && penable && pwrite && paddr == 1'(wtns_pkg::CSR_PICK_COUNT)) begin
         pick_ff <= pwdata[wtns_pkg::PICK_W-1:0];
      end
   end
   assign prdata = {{(32 - wtns_pkg::PICK_W){1'b0}}, pick_ff};

   // Controller owns the handshakes and the last-pick flag.
   wtns_ctrl #(.MAX_PICKS(MAX_PICKS)) u_ctrl (
      .clock, .reset, .req_valid, .req_ready,
      .last_song(req_data.last_song), .pick_count(pick_ff),
      .rsp_valid, .rsp_ready, .last_pick, .sts, .cmd
   );

   // Datapath holds the counter, the multiplier and the ranking chain.
   wtns_datapath #(.MAX_PICKS(MAX_PICKS), .MAX_SONGS(MAX_SONGS)) u_dp (
      .clock, .reset, .cmd, .play_count(req_data.play_count), .sts, .head_index
   );

   assign rsp_data.song_index = head_index;
   assign rsp_data.last_pick  = last_pick;
endmodule
`default_nettype wire
